// ----- design/lru_key_value_cache_top_defines.svh -----
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared property wrappers for the cache control logic.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define LKV_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LKV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/lkv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Request/response payloads, chain link and update command types.
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  // which cell takes the update
  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_HIT,
    SEL_LRU,
    SEL_FREE
  } sel_e;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
  } rsp_t;

  // search record handed from cell to cell
  typedef struct packed {
    logic active;
    logic hit;
    logic free_taken;
  } link_t;

  // update broadcast to all cells
  typedef struct packed {
    logic               upd;
    sel_e               sel;
    logic               write;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } cmd_t;

endpackage

// ----- design/lkv_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache cell
// One entry: key, data, valid and recency rank, plus search flags.
// ----------------------------------------------------------------------------
module lkv_cell import lkv_pkg::*; #(
  parameter int RW = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  link_t                link_i,
  input  logic signed [31:0]   link_data_i,
  input  logic [RW-1:0]        link_rank_i,
  output link_t                link_o,
  output logic signed [31:0]   link_data_o,
  output logic [RW-1:0]        link_rank_o,
  input  logic signed [31:0]   key_i,
  input  logic [RW-1:0]        lru_rank_i,
  input  cmd_t                 cmd_i,
  input  logic [RW-1:0]        cmd_rank_i
);

  logic               valid_q, valid_d;
  logic [RW-1:0]      rank_q, rank_d;
  logic signed [31:0] key_q, data_q;
  logic               hit_q, hit_d;
  logic               free_q, free_d;
  logic               lru_q, lru_d;
  link_t              link_q, link_d;
  logic signed [31:0] link_data_q, link_data_d;
  logic [RW-1:0]      link_rank_q, link_rank_d;
  logic               match;
  logic               tgt;
  logic               age;

  assign match = valid_q && (key_q == key_i);

  always_comb begin
    link_d.active     = link_i.active;
    link_d.hit        = link_i.hit | (link_i.active & match);
    link_d.free_taken = link_i.free_taken | (link_i.active & ~valid_q);
    link_data_d       = match ? data_q : link_data_i;
    link_rank_d       = match ? rank_q : link_rank_i;
  end

  // flags latched as the record passes; used by the following update
  always_comb begin
    hit_d  = hit_q;
    free_d = free_q;
    lru_d  = lru_q;
    if (link_i.active) begin
      hit_d  = match;
      free_d = ~valid_q & ~link_i.free_taken;
      lru_d  = valid_q && (rank_q == lru_rank_i);
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_HIT:  tgt = hit_q;
      SEL_LRU:  tgt = lru_q;
      SEL_FREE: tgt = free_q;
      default:  tgt = 1'b0;
    endcase
  end

  assign age = cmd_i.upd && (cmd_i.sel != SEL_NONE) && valid_q && !tgt
               && (rank_q < cmd_rank_i);

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (cmd_i.upd && tgt) begin
      valid_d = 1'b1;
      rank_d  = '0;
    end else if (age) begin
      rank_d = rank_q + RW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
      lru_q   <= 1'b0;
      link_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      hit_q   <= hit_d;
      free_q  <= free_d;
      lru_q   <= lru_d;
      link_q  <= link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    link_data_q <= link_data_d;
    link_rank_q <= link_rank_d;
    if (cmd_i.upd && tgt && cmd_i.write) begin
      key_q  <= cmd_i.key;
      data_q <= cmd_i.value;
    end
  end

  assign link_o      = link_q;
  assign link_data_o = link_data_q;
  assign link_rank_o = link_rank_q;

endmodule

// ----- design/lkv_ctrl.sv -----
`timescale 1ns / 1ps
`include "lru_key_value_cache_top_defines.svh"
// ----------------------------------------------------------------------------
// LRU key-value cache controller
// Launches the search record, decides hit/evict/insert, issues the update.
// ----------------------------------------------------------------------------
module lkv_ctrl import lkv_pkg::*; #(
  parameter int ENTRIES = 16,
  parameter int RW      = 4,
  parameter int HW      = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  req_t               req_i,
  output rsp_t               rsp_o,
  output logic               done_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CAP_W-1:0]   cfg_data_i,
  output link_t              inj_o,
  output logic signed [31:0] key_o,
  output logic [RW-1:0]      lru_rank_o,
  input  link_t              tail_i,
  input  logic signed [31:0] tail_data_i,
  input  logic [RW-1:0]      tail_rank_i,
  output cmd_t               cmd_o,
  output logic [RW-1:0]      cmd_rank_o
);

  localparam int CW = (HW > CAP_W) ? HW : CAP_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESP
  } state_e;

  state_e             state_q;
  req_t               req_q;
  link_t              inj_q, inj_d;
  logic [HW-1:0]      held_q;
  logic [CAP_W-1:0]   cap_q;
  rsp_t               rsp_q;
  cmd_t               cmd_q, cmd_d;
  logic [RW-1:0]      cmd_rank_q;

  logic               accept;
  logic [CW-1:0]      cap_ext, eff_cap;
  logic               full;
  logic [RW-1:0]      lru_rank;
  cmd_t               cmd_dec;
  logic [RW-1:0]      rank_dec;
  rsp_t               rsp_dec;
  logic               grow;

  assign accept   = start && (state_q != ST_SEARCH);
  assign busy     = (state_q == ST_SEARCH);
  assign lru_rank = RW'(held_q - HW'(1));

  // capacity clamped to 1..ENTRIES
  assign cap_ext = CW'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full = (CW'(held_q) >= eff_cap);

  always_comb begin
    cmd_dec.upd   = 1'b1;
    cmd_dec.sel   = SEL_NONE;
    cmd_dec.write = (req_q.operation == OP_PUT);
    cmd_dec.key   = req_q.key;
    cmd_dec.value = req_q.value;
    rank_dec      = tail_rank_i;
    rsp_dec.found      = tail_i.hit;
    rsp_dec.read_value = req_q.value;
    grow          = 1'b0;
    if (tail_i.hit) begin
      cmd_dec.sel = SEL_HIT;
      if (req_q.operation == OP_GET) begin
        rsp_dec.read_value = tail_data_i;
      end
    end else if (req_q.operation == OP_GET) begin
      rsp_dec.read_value = MISS_VALUE;
    end else if (full) begin
      cmd_dec.sel = SEL_LRU;
      rank_dec    = lru_rank;
    end else begin
      // every held entry ages by one
      cmd_dec.sel = SEL_FREE;
      rank_dec    = RW'(held_q);
      grow        = 1'b1;
    end
  end

  // launch record and update command are single-cycle pulses
  always_comb begin
    inj_d        = '0;
    inj_d.active = accept;
    cmd_d        = '0;
    if (state_q == ST_SEARCH && tail_i.active) begin
      cmd_d = cmd_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      req_q      <= '0;
      inj_q      <= '0;
      held_q     <= '0;
      cap_q      <= CAP_RESET;
      rsp_q      <= '0;
      cmd_q      <= '0;
      cmd_rank_q <= '0;
    end else begin
      inj_q <= inj_d;
      cmd_q <= cmd_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (accept) begin
        req_q <= req_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (tail_i.active) begin
            state_q    <= ST_RESP;
            cmd_rank_q <= rank_dec;
            rsp_q      <= rsp_dec;
            if (grow) begin
              held_q <= held_q + HW'(1);
            end
          end
        end
        ST_RESP: begin
          state_q <= accept ? ST_SEARCH : ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;
  assign rsp_o       = rsp_q;
  assign done_o      = (state_q == ST_RESP);
  assign inj_o       = inj_q;
  assign key_o       = req_q.key;
  assign lru_rank_o  = lru_rank;
  assign cmd_o       = cmd_q;
  assign cmd_rank_o  = cmd_rank_q;

  `LKV_ASSERT_SAME(a_tail_in_search, tail_i.active, state_q == ST_SEARCH, "record out of search")
  `LKV_ASSERT_NEXT(a_accept_injects, start && !busy, inj_q.active && state_q == ST_SEARCH, "no launch")
  `LKV_ASSERT_SAME(a_held_bound, 1'b1, held_q <= HW'(ENTRIES), "held count beyond entries")
  `LKV_ASSERT_NEXT(a_insert_grows, state_q == ST_SEARCH && tail_i.active && grow, held_q == $past(held_q) + HW'(1), "insert without count")

endmodule

// ----- design/lru_key_value_cache_top.sv -----
`timescale 1ns / 1ps
// Sequence: the accepted request launches a search record that walks the cell chain
// one cell per cycle; the controller then registers the response and raises done_o.
// No new request is taken while busy; start is taken again in the result cycle.
// Reset: cache empty, capacity 16; no clearing pass, usable right away.
// The result is on rsp_o for the single done_o cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// LRU key-value cache top level
// Fully associative get/put cache built as a chain of entry cells.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top import lkv_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output rsp_t             rsp_o,
  output logic             done_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int HW = $clog2(ENTRIES + 1);

  link_t              link   [ENTRIES+1];
  logic signed [31:0] ldata  [ENTRIES+1];
  logic [RW-1:0]      lrank  [ENTRIES+1];
  logic signed [31:0] key;
  logic [RW-1:0]      lru_rank;
  cmd_t               cmd;
  logic [RW-1:0]      cmd_rank;

  assign ldata[0] = '0;
  assign lrank[0] = '0;

  lkv_ctrl #(
    .ENTRIES (ENTRIES),
    .RW      (RW),
    .HW      (HW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .done_o      (done_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .inj_o       (link[0]),
    .key_o       (key),
    .lru_rank_o  (lru_rank),
    .tail_i      (link[ENTRIES]),
    .tail_data_i (ldata[ENTRIES]),
    .tail_rank_i (lrank[ENTRIES]),
    .cmd_o       (cmd),
    .cmd_rank_o  (cmd_rank)
  );

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkv_cell #(
      .RW (RW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .link_i      (link[g]),
      .link_data_i (ldata[g]),
      .link_rank_i (lrank[g]),
      .link_o      (link[g+1]),
      .link_data_o (ldata[g+1]),
      .link_rank_o (lrank[g+1]),
      .key_i       (key),
      .lru_rank_i  (lru_rank),
      .cmd_i       (cmd),
      .cmd_rank_i  (cmd_rank)
    );
  end

endmodule

// ----- sim/lkv_access_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache access checker
// Watches the request, response and capacity channels, keeps its own copy of
// the cache contents and recency ranks, and compares each response with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module lkv_access_checker import lkv_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  req_t             req_i,
  input  rsp_t             rsp_i,
  input  logic             done_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output int               outstanding_o,
  output int               fail_count_o
);

  localparam int REPORT_LIMIT = 10;

  logic signed [31:0] line_key  [ENTRIES];
  logic signed [31:0] line_data [ENTRIES];
  bit                 line_valid[ENTRIES];
  int unsigned        line_rank [ENTRIES];
  int                 held_lines;
  logic [CAP_W-1:0]   capacity_reg;

  rsp_t pending_rsp_q[$];
  rsp_t expected_rsp;
  int   mismatches;

  function automatic int usable_lines();
    int lines;
    lines = int'(capacity_reg);
    if (lines < 1) lines = 1;
    if (lines > ENTRIES) lines = ENTRIES;
    return lines;
  endfunction

  // rank 0 is most recent; lines that were more recent than s age by one
  function automatic void mark_recent(int s);
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && i != s && line_rank[i] < line_rank[s]) line_rank[i]++;
    end
    line_rank[s] = 0;
  endfunction

  function automatic rsp_t access_cache(req_t r);
    rsp_t rsp;
    int   slot;
    int   victim;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && line_valid[i] && line_key[i] == r.key) slot = i;
    end
    if (r.operation == OP_GET) begin
      if (slot >= 0) begin
        mark_recent(slot);
        rsp.found      = 1'b1;
        rsp.read_value = line_data[slot];
      end else begin
        rsp.found      = 1'b0;
        rsp.read_value = MISS_VALUE;
      end
      return rsp;
    end
    rsp.found      = (slot >= 0);
    rsp.read_value = r.value;
    if (slot >= 0) begin
      line_data[slot] = r.value;
      mark_recent(slot);
    end else if (held_lines >= usable_lines() && held_lines > 0) begin
      // full (or capacity lowered below the fill): oldest line is replaced
      victim = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim])) victim = i;
      end
      line_key[victim]  = r.key;
      line_data[victim] = r.value;
      mark_recent(victim);
    end else begin
      slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !line_valid[i]) slot = i;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_valid[i]) line_rank[i]++;
      end
      line_valid[slot] = 1'b1;
      line_key[slot]   = r.key;
      line_data[slot]  = r.value;
      line_rank[slot]  = 0;
      held_lines++;
    end
    return rsp;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        line_valid[i] = 1'b0;
        line_rank[i]  = 0;
      end
      held_lines   = 0;
      capacity_reg = CAP_RESET;
      mismatches   = 0;
      pending_rsp_q.delete();
      outstanding_o <= 0;
      fail_count_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) capacity_reg = cfg_data_i;
      // retire before predicting: a new request may be taken in the result cycle
      if (done_i === 1'b1) begin
        if (pending_rsp_q.size() == 0) begin
          report_mismatch($sformatf("unexpected response found=%0b value=%0d",
                                    rsp_i.found, rsp_i.read_value));
        end else begin
          expected_rsp = pending_rsp_q.pop_front();
          if (rsp_i.found !== expected_rsp.found ||
              rsp_i.read_value !== expected_rsp.read_value) begin
            report_mismatch($sformatf("response mismatch: exp found=%0b value=%0d, got found=%0b value=%0d",
                                      expected_rsp.found, expected_rsp.read_value,
                                      rsp_i.found, rsp_i.read_value));
          end
        end
      end
      if (start_i && !busy_i) pending_rsp_q.push_back(access_cache(req_i));
      outstanding_o <= pending_rsp_q.size();
      fail_count_o  <= mismatches;
    end
  end

endmodule

// ----- sim/lru_key_value_cache_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Directed get/put sequence over key and value extremes, then random phases
// under a range of capacities with random request gaps; the checker predicts
// every response.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top_test;
  import lkv_pkg::*;

  localparam int ENTRIES       = 16;
  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 11;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 120;
  localparam int KEY_POOL      = 24;
  localparam int MAX_GAP       = 24;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  req_t             req_i       = '0;
  logic             cfg_valid_i = 1'b0;
  logic [CAP_W-1:0] cfg_data_i  = '0;
  logic             busy;
  logic             done_o;
  logic             cfg_ready_o;
  rsp_t             rsp_o;

  int          outstanding;
  int          fail_count;
  int unsigned cycle_count = 0;
  bit          idle_allowed = 1'b1;

  logic signed [31:0] key_pool[KEY_POOL];
  logic [CAP_W-1:0]   phase_capacity[PHASES] = '{5'd1, 5'd16, 5'd2, 5'd31, 5'd5,
                                                  5'd0, 5'd8, 5'd17, 5'd3, 5'd16};

  lru_key_value_cache_top #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_o      (rsp_o),
    .done_o     (done_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  lkv_access_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .rsp_i        (rsp_o),
    .done_i       (done_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .outstanding_o(outstanding),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // start stays high through busy; a gap drops it after the accepting edge
  task automatic issue_request(input logic op, input logic signed [31:0] k,
                               input logic signed [31:0] v);
    start <= 1'b1;
    req_i <= '{operation: op, key: k, value: v};
    do @(posedge clk_i); while (busy !== 1'b0);
    if (idle_allowed && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  // mostly a window of the pool, so hits and evictions both come often
  function automatic logic signed [31:0] pick_key(int window);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return key_pool[$urandom_range(0, window)];
    if (sel < 90) return $urandom;
    return pick_extreme();
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 99) < 85) return $urandom;
    return pick_extreme();
  endfunction

  initial begin
    int lines;
    int window;
    for (int i = 0; i < KEY_POOL; i++) begin
      if (i < 4) key_pool[i] = (i == 0) ? KEY_MIN : (i == 1) ? KEY_MAX : (i == 2) ? 0 : -1;
      else if (i % 2 == 0) key_pool[i] = $urandom_range(0, 63);
      else key_pool[i] = $urandom;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset capacity, empty cache
    issue_request(OP_GET, 32'sd0, 32'sd99);
    issue_request(OP_PUT, KEY_MIN, KEY_MAX);
    issue_request(OP_PUT, KEY_MAX, KEY_MIN);
    issue_request(OP_PUT, -32'sd1, 32'sd0);
    issue_request(OP_PUT, 32'sd0, -32'sd1);
    issue_request(OP_GET, KEY_MIN, 32'sd0);
    issue_request(OP_GET, -32'sd1, KEY_MAX);
    issue_request(OP_PUT, -32'sd1, 32'sd5);
    issue_request(OP_GET, 32'sd12345, 32'sd0);
    // a hit whose stored value equals the miss marker
    issue_request(OP_GET, 32'sd0, 32'sd0);

    // zero capacity acts as one, and sits below the current fill
    wait_drained();
    write_capacity(5'd0);
    issue_request(OP_PUT, 32'sd7, 32'sd7);
    issue_request(OP_GET, 32'sd7, 32'sd0);
    issue_request(OP_GET, KEY_MAX, 32'sd0);

    // above the entry count: clamped
    wait_drained();
    write_capacity(5'd31);
    issue_request(OP_PUT, 32'sd8, 32'sd8);
    issue_request(OP_GET, 32'sd8, 32'sd0);

    wait_drained();
    write_capacity(5'd1);
    issue_request(OP_PUT, 32'sd9, 32'sd9);
    issue_request(OP_PUT, 32'sd10, 32'sd10);
    issue_request(OP_GET, 32'sd9, 32'sd0);
    issue_request(OP_GET, 32'sd10, 32'sd0);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_capacity(phase_capacity[p]);
      lines = int'(phase_capacity[p]);
      if (lines < 1) lines = 1;
      if (lines > ENTRIES) lines = ENTRIES;
      window = (lines + 4 > KEY_POOL - 1) ? KEY_POOL - 1 : lines + 4;
      idle_allowed = !(p == 3 || p == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        issue_request(logic'($urandom_range(0, 1)), pick_key(window), pick_value());
      end
    end

    wait_drained();
    repeat (ENTRIES + 4) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
